// ===== hw/rtl/bcomp_pkg.sv =====
// ----------------------------------------------------------------------------
// bcomp_pkg
// Types, constants and helpers shared by the barometer compensation unit.
// ----------------------------------------------------------------------------
package bcomp_pkg;

    localparam int DW    = 32;
    localparam int CNT_W = 6;

    localparam logic [31:0] C_B6_OFS   = 32'd4000;
    localparam logic [31:0] C_B4_OFS   = 32'd32768;
    localparam logic [31:0] C_P_SCALE  = 32'd50000;
    localparam logic [31:0] C_MSB      = 32'h8000_0000;
    localparam logic [31:0] C_K1       = 32'd3038;
    localparam logic [31:0] C_K2       = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] C_K3       = 32'd3791;

    typedef enum logic [2:0] {
        REG_AC1_AC2  = 3'd0,
        REG_AC3_AC4  = 3'd1,
        REG_AC5_AC6  = 3'd2,
        REG_B1_B2    = 3'd3,
        REG_MC_MD    = 3'd4,
        REG_OSS      = 3'd5
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_T_MUL, ST_T_CHK, ST_T_DIV,
        ST_P_SQ, ST_P_X1, ST_P_X2, ST_P_T1, ST_P_T2, ST_P_B4, ST_P_B7,
        ST_P_CHK, ST_P_DIV, ST_P_PH, ST_P_X1B, ST_P_X2B, ST_FIN
    } state_t;

    typedef struct packed {
        logic            start;
        logic [DW-1:0]   a;
        logic [DW-1:0]   b;
    } unit_req_t;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        sext16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input int s);
        asr = 32'($signed(v) >>> s);
    endfunction

endpackage

// ===== hw/rtl/bcomp_mul.sv =====
// ----------------------------------------------------------------------------
// bcomp_mul
// Bit-serial shift-add multiplier, low word of the product, one bit a cycle.
// ----------------------------------------------------------------------------
module bcomp_mul
    import bcomp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  unit_req_t       req,
    output logic            done,
    output logic [DW-1:0]   prod
);

    logic [DW-1:0]    a_reg, a_next;
    logic [DW-1:0]    b_reg, b_next;
    logic [DW-1:0]    acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
            cnt_next  = CNT_W'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = {a_reg[DW-2:0], 1'b0};
            b_next   = {1'b0, b_reg[DW-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== hw/rtl/bcomp_div.sv =====
// ----------------------------------------------------------------------------
// bcomp_div
// Restoring unsigned divider, one quotient bit a cycle; user must keep divisor nonzero, unchecked.
// ----------------------------------------------------------------------------
module bcomp_div
    import bcomp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  unit_req_t       req,
    output logic            done,
    output logic [DW-1:0]   quo
);

    logic [DW-1:0]    n_reg, n_next;
    logic [DW-1:0]    d_reg, d_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DW:0]      rem_sh;
    logic             ge;

    always_comb
    begin
        rem_sh    = {rem_reg, n_reg[DW-1]};
        ge        = rem_sh >= {1'b0, d_reg};
        n_next    = n_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            n_next    = req.a;
            d_next    = req.b;
            rem_next  = '0;
            cnt_next  = CNT_W'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DW'(rem_sh - {1'b0, d_reg}) : rem_sh[DW-1:0];
            n_next   = {n_reg[DW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = n_reg;

endmodule

// ===== hw/rtl/barometer_temp_pressure_compensation_unit.sv =====
// ----------------------------------------------------------------------------
// barometer_temp_pressure_compensation_unit
// Integer temperature and pressure compensation on a serial multiplier and
// a serial divider under a step sequencer.
//
//   channel  dir  word
//   s_*      in   tdata[23:0] raw_reading, tuser[0] func
//   m_*      out  tdata[31:0] value, tuser[0] kind, tuser[1] div_by_zero
//   cfg_*    in   cfg_addr register index, cfg_wdata[31:0]
//
// Temperature takes one multiply and one divide from accept to output word,
// pressure ten multiplies and one divide, each holding its step until done.
// A zero divisor skips the divide. One word in flight; s_tready is high
// only when the sequencer is idle.
// The result register holds a word while m_tready is low; a finished word
// waits in the last step until the register frees.
// Reset clears calibration, oversampling and the stored B5.
// ----------------------------------------------------------------------------
module barometer_temp_pressure_compensation_unit
    import bcomp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // raw_reading
    input  logic [0:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // value
    output logic [1:0]  m_tuser,   // kind, div_by_zero
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    logic [31:0] ac12_reg, ac34_reg, ac56_reg, b12_reg, mcmd_reg;
    logic [1:0]  oss_reg;
    logic [31:0] b5_reg, b5_next;

    state_t      state_reg, state_next;
    logic        go_reg, go_next;
    logic        func_reg;
    logic [23:0] raw_reg;
    logic [31:0] x1_reg, x1_next;
    logic [31:0] sq_reg, sq_next;
    logic [31:0] x3_reg, x3_next;
    logic [31:0] b3_reg, b3_next;
    logic [31:0] b4_reg, b4_next;
    logic [31:0] b7_reg, b7_next;
    logic [31:0] p_reg, p_next;
    logic [31:0] res_reg, res_next;
    logic        dz_reg, dz_next;

    logic        ov_reg, ov_next;
    logic [31:0] ov_value_reg, ov_value_next;
    logic        ov_kind_reg, ov_kind_next;
    logic        ov_dz_reg, ov_dz_next;

    unit_req_t   mreq, dreq;
    logic        mul_done, div_done;
    logic [31:0] prod, quo;
    logic        fire, mfin, dfin;

    logic [31:0] b6, den, num, tmp, t2, sdq;
    logic        neg;

    bcomp_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .done(mul_done), .prod(prod));
    bcomp_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(div_done), .quo(quo));

    always_comb
    begin
        b6    = b5_reg - C_B6_OFS;
        den   = x1_reg + sext16(mcmd_reg[15:0]);
        num   = {sext16(mcmd_reg[31:16])} << 11;
        neg   = num[31] != den[31];
        fire  = !go_reg;
        mfin  = go_reg && mul_done;
        dfin  = go_reg && div_done;
        sdq   = neg ? (32'd0 - quo) : quo;
        tmp   = '0;
        t2    = '0;

        state_next = state_reg;
        go_next    = go_reg;
        x1_next    = x1_reg;
        sq_next    = sq_reg;
        x3_next    = x3_reg;
        b3_next    = b3_reg;
        b4_next    = b4_reg;
        b7_next    = b7_reg;
        p_next     = p_reg;
        res_next   = res_reg;
        dz_next    = dz_reg;
        b5_next    = b5_reg;
        mreq       = '0;
        dreq       = '0;
        s_tready   = 1'b0;

        ov_next       = ov_reg && !m_tready;
        ov_value_next = ov_value_reg;
        ov_kind_next  = ov_kind_reg;
        ov_dz_next    = ov_dz_reg;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                go_next  = 1'b0;
                res_next = '0;
                dz_next  = 1'b0;
                if (s_tvalid)
                begin
                    state_next = s_tuser[0] ? ST_P_SQ : ST_T_MUL;
                end
            end
            ST_T_MUL:
            begin
                mreq.start = fire;
                mreq.a     = {16'd0, raw_reg[15:0]} - {16'd0, ac56_reg[15:0]};
                mreq.b     = {16'd0, ac56_reg[31:16]};
                go_next    = 1'b1;
                if (mfin)
                begin
                    x1_next    = asr(prod, 15);
                    go_next    = 1'b0;
                    state_next = ST_T_CHK;
                end
            end
            ST_T_CHK:
            begin
                if (den == '0)
                begin
                    dz_next    = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_T_DIV;
                end
            end
            ST_T_DIV:
            begin
                dreq.start = fire;
                dreq.a     = num[31] ? (32'd0 - num) : num;
                dreq.b     = den[31] ? (32'd0 - den) : den;
                go_next    = 1'b1;
                if (dfin)
                begin
                    tmp        = x1_reg + sdq;
                    b5_next    = tmp;
                    res_next   = asr(tmp + 32'd8, 4);
                    go_next    = 1'b0;
                    state_next = ST_FIN;
                end
            end
            ST_P_SQ:
            begin
                mreq.start = fire;
                mreq.a     = b6;
                mreq.b     = b6;
                go_next    = 1'b1;
                if (mfin)
                begin
                    sq_next    = asr(prod, 12);
                    go_next    = 1'b0;
                    state_next = ST_P_X1;
                end
            end
            ST_P_X1:
            begin
                mreq.start = fire;
                mreq.a     = sext16(b12_reg[15:0]);
                mreq.b     = sq_reg;
                go_next    = 1'b1;
                if (mfin)
                begin
                    x1_next    = asr(prod, 11);
                    go_next    = 1'b0;
                    state_next = ST_P_X2;
                end
            end
            ST_P_X2:
            begin
                mreq.start = fire;
                mreq.a     = sext16(ac12_reg[15:0]);
                mreq.b     = b6;
                go_next    = 1'b1;
                if (mfin)
                begin
                    tmp        = (sext16(ac12_reg[31:16]) << 2) + x1_reg + asr(prod, 11);
                    t2         = tmp << oss_reg;
                    b3_next    = asr(t2 + 32'd2, 2);
                    go_next    = 1'b0;
                    state_next = ST_P_T1;
                end
            end
            ST_P_T1:
            begin
                mreq.start = fire;
                mreq.a     = sext16(ac34_reg[31:16]);
                mreq.b     = b6;
                go_next    = 1'b1;
                if (mfin)
                begin
                    x1_next    = asr(prod, 13);
                    go_next    = 1'b0;
                    state_next = ST_P_T2;
                end
            end
            ST_P_T2:
            begin
                mreq.start = fire;
                mreq.a     = sext16(b12_reg[31:16]);
                mreq.b     = sq_reg;
                go_next    = 1'b1;
                if (mfin)
                begin
                    x3_next    = asr(x1_reg + asr(prod, 16) + 32'd2, 2);
                    go_next    = 1'b0;
                    state_next = ST_P_B4;
                end
            end
            ST_P_B4:
            begin
                mreq.start = fire;
                mreq.a     = {16'd0, ac34_reg[15:0]};
                mreq.b     = x3_reg + C_B4_OFS;
                go_next    = 1'b1;
                if (mfin)
                begin
                    b4_next    = prod >> 15;
                    go_next    = 1'b0;
                    state_next = ST_P_B7;
                end
            end
            ST_P_B7:
            begin
                mreq.start = fire;
                mreq.a     = ({8'd0, raw_reg} >> (4'd8 - {2'd0, oss_reg})) - b3_reg;
                mreq.b     = C_P_SCALE >> oss_reg;
                go_next    = 1'b1;
                if (mfin)
                begin
                    b7_next    = prod;
                    go_next    = 1'b0;
                    state_next = ST_P_CHK;
                end
            end
            ST_P_CHK:
            begin
                if (b4_reg == '0)
                begin
                    dz_next    = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_P_DIV;
                end
            end
            ST_P_DIV:
            begin
                dreq.start = fire;
                dreq.a     = (b7_reg < C_MSB) ? (b7_reg << 1) : b7_reg;
                dreq.b     = b4_reg;
                go_next    = 1'b1;
                if (dfin)
                begin
                    p_next     = (b7_reg < C_MSB) ? quo : (quo << 1);
                    go_next    = 1'b0;
                    state_next = ST_P_PH;
                end
            end
            ST_P_PH:
            begin
                mreq.start = fire;
                mreq.a     = asr(p_reg, 8);
                mreq.b     = asr(p_reg, 8);
                go_next    = 1'b1;
                if (mfin)
                begin
                    x1_next    = prod;
                    go_next    = 1'b0;
                    state_next = ST_P_X1B;
                end
            end
            ST_P_X1B:
            begin
                mreq.start = fire;
                mreq.a     = x1_reg;
                mreq.b     = C_K1;
                go_next    = 1'b1;
                if (mfin)
                begin
                    x1_next    = asr(prod, 16);
                    go_next    = 1'b0;
                    state_next = ST_P_X2B;
                end
            end
            ST_P_X2B:
            begin
                mreq.start = fire;
                mreq.a     = C_K2;
                mreq.b     = p_reg;
                go_next    = 1'b1;
                if (mfin)
                begin
                    res_next   = p_reg + asr(x1_reg + asr(prod, 16) + C_K3, 4);
                    go_next    = 1'b0;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next       = 1'b1;
                    ov_value_next = res_reg;
                    ov_kind_next  = func_reg;
                    ov_dz_next    = dz_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            go_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            b5_reg    <= '0;
            ac12_reg  <= '0;
            ac34_reg  <= '0;
            ac56_reg  <= '0;
            b12_reg   <= '0;
            mcmd_reg  <= '0;
            oss_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;
            ov_reg    <= ov_next;
            b5_reg    <= b5_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_AC1_AC2: ac12_reg <= cfg_wdata;
                    REG_AC3_AC4: ac34_reg <= cfg_wdata;
                    REG_AC5_AC6: ac56_reg <= cfg_wdata;
                    REG_B1_B2:   b12_reg  <= cfg_wdata;
                    REG_MC_MD:   mcmd_reg <= cfg_wdata;
                    REG_OSS:     oss_reg  <= cfg_wdata[1:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            func_reg <= s_tuser[0];
            raw_reg  <= s_tdata;
        end
        x1_reg       <= x1_next;
        sq_reg       <= sq_next;
        x3_reg       <= x3_next;
        b3_reg       <= b3_next;
        b4_reg       <= b4_next;
        b7_reg       <= b7_next;
        p_reg        <= p_next;
        res_reg      <= res_next;
        dz_reg       <= dz_next;
        ov_value_reg <= ov_value_next;
        ov_kind_reg  <= ov_kind_next;
        ov_dz_reg    <= ov_dz_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = ov_value_reg;
    assign m_tuser  = {ov_dz_reg, ov_kind_reg};

endmodule

// ===== hw/rtl/bcomp_checker.sv =====
// ----------------------------------------------------------------------------
// bcomp_checker
// Port-level checks on the compensation unit, bound to the top level.
// ----------------------------------------------------------------------------
module bcomp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata == 32'd0)
        else $error("div_by_zero word with nonzero value");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

endmodule

bind barometer_temp_pressure_compensation_unit bcomp_checker u_bcomp_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
